/* design/b64enc_pkg.sv */
package b64enc_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [6:0] PadChar = 7'h3D;

  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } b64enc_entry_t;

  function automatic logic [6:0] b64enc_sym(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 7'h2B;
    end else begin
      r = 7'h2F;
    end
    return r;
  endfunction

endpackage

/* design/b64enc_if.sv */
interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       final_char;

  modport source (output valid, output ascii_char, output final_char, input ready);
  modport sink (input valid, input ascii_char, input final_char, output ready);
endinterface

/* design/base64_stream_encoder.sv */
// Channel  Dir  Payload                          Transaction
// in_i     in   data_byte[7:0], final_byte       valid && ready
// out_o    out  ascii_char[6:0], final_char      valid && ready
//
// Each byte yields one entry of one to four characters, formed combinationally.
// The output register emits one character per cycle while out_o is ready
// and the queue is not empty, four characters per three bytes on average.
// Input stalls only when the entry queue is full; reset clears group state.
module base64_stream_encoder import b64enc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64enc_in_if.sink     in_i,
  b64enc_out_if.source  out_o
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  b64enc_entry_t push_entry, pop_entry;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  b64enc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  b64enc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_pop_o   (pop_ready),
    .q_entry_i (pop_entry),
    .out_o     (out_o)
  );

endmodule

/* design/b64enc_front.sv */
module b64enc_front import b64enc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64enc_in_if.sink     in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output b64enc_entry_t push_entry_o
);

  logic [1:0]    pos_q, pos_d;
  logic [3:0]    left_q, left_d;
  logic          accept;
  logic [7:0]    b;
  logic          fin;
  b64enc_entry_t entry;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign push_entry_o = entry;
  assign accept       = in_i.valid && push_ready_i;
  assign b            = in_i.data_byte;
  assign fin          = in_i.final_byte;

  always_comb begin
    entry.chars    = {4{PadChar}};
    entry.last_idx = 2'd0;
    entry.fin      = fin;
    pos_d          = pos_q;
    left_d         = left_q;
    case (pos_q)
      2'd1: begin
        entry.chars[0] = b64enc_sym({left_q[1:0], b[7:4]});
        if (fin) begin
          entry.chars[1] = b64enc_sym({b[3:0], 2'b00});
          entry.chars[2] = PadChar;
          entry.last_idx = 2'd2;
          pos_d          = 2'd0;
          left_d         = 4'd0;
        end else begin
          pos_d  = 2'd2;
          left_d = b[3:0];
        end
      end
      2'd2: begin
        entry.chars[0] = b64enc_sym({left_q, b[7:6]});
        entry.chars[1] = b64enc_sym(b[5:0]);
        entry.last_idx = 2'd1;
        pos_d          = 2'd0;
        left_d         = 4'd0;
      end
      default: begin
        entry.chars[0] = b64enc_sym(b[7:2]);
        if (fin) begin
          entry.chars[1] = b64enc_sym({b[1:0], 4'b0000});
          entry.chars[2] = PadChar;
          entry.chars[3] = PadChar;
          entry.last_idx = 2'd3;
          pos_d          = 2'd0;
          left_d         = 4'd0;
        end else begin
          pos_d  = 2'd1;
          left_d = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      left_q <= 4'd0;
    end else if (accept) begin
      pos_q  <= pos_d;
      left_q <= left_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3) else $error("group position out of range");

  a_fin_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fin |=> pos_q == 2'd0 && left_q == 4'd0)
    else $error("final byte did not restart the group");

endmodule

/* design/b64enc_fifo.sv */
module b64enc_fifo import b64enc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  b64enc_entry_t push_entry_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output b64enc_entry_t pop_entry_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64enc_entry_t entries_q [Depth];
  logic [IdxW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_entry_o  = entries_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == IdxW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == IdxW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_entry_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 || cnt_q == CntW'(Depth) |-> wptr_q == rptr_q)
    else $error("queue pointers disagree with count");

endmodule

/* design/b64enc_back.sv */
module b64enc_back import b64enc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  b64enc_entry_t q_entry_i,
  b64enc_out_if.source  out_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] char_q;
  logic       fin_q;
  logic       load, take, last;

  assign load    = !out_valid_q || out_o.ready;
  assign take    = load && q_valid_i;
  assign last    = idx_q == q_entry_i.last_idx;
  assign q_pop_o = take && last;

  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = char_q;
  assign out_o.final_char = fin_q;

  always_comb begin
    out_valid_d = load ? q_valid_i : out_valid_q;
    idx_d       = idx_q;
    if (take) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= q_entry_i.chars[idx_q];
      fin_q  <= q_entry_i.fin && last;
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> idx_q <= q_entry_i.last_idx)
    else $error("character index past end of entry");

endmodule
